// ===== hw/rtl/atsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive time step controller package
// Shared constants: default widths, register indexes and output mode codes.
// ----------------------------------------------------------------------------
package atsc_pkg;

  localparam int TIME_BITS_DEF      = 48;
  localparam int TIME_FRAC_BITS_DEF = 32;
  localparam int SPEED_BITS_DEF     = 32;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int GROW_W     = 16;
  localparam int GROW_FRAC  = 12;
  localparam int COURANT_W  = 32;
  localparam int COUNT_W    = 32;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DT          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DT          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COURANT_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_INTERVAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FINISH_TIME     = 3'd7;

  localparam logic [MODE_W-1:0] MODE_TIME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;

  localparam logic [GROW_W-1:0]     GROW_RESET = 16'd4096;
  localparam logic [CFG_DATA_W-1:0] MAX_DT_RESET = 48'hFFFF_FFFF_FFFF;

endpackage

// ===== hw/rtl/atsc_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Bit-serial unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atsc_div #(
  parameter int NUM_W = atsc_pkg::TIME_BITS_DEF,
  parameter int DEN_W = atsc_pkg::COURANT_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import atsc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   part;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign part = {rem_r, quo_r[NUM_W-1]};
  assign diff = part - {1'b0, den_r};
  assign fits = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], fits};
        rem_r <= fits ? diff[DEN_W-1:0] : part[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("divider busy with empty count");

endmodule

// ===== hw/rtl/adaptive_time_step_controller_core.sv =====
// ----------------------------------------------------------------------------
// Adaptive time step controller
// Picks a CFL limited time step per simulation step and advances sim time.
// ----------------------------------------------------------------------------
// Each input transaction carries the largest particle speed of one simulation
// step and produces exactly one result transaction. The Courant step is formed
// by a bit-serial restoring divider that resolves one quotient bit per cycle
// (TIME_FRAC_BITS + SPEED_BITS - 16 bits, at least 32 and at most 64, which is
// 48 at the default widths), while a serial multiplier forms the growth limit
// alongside it; five short steps then take the minimum, advance the time and
// decide the output. A new transaction is accepted while the previous result
// waits. Configuration writes are accepted in every cycle.
module adaptive_time_step_controller_core #(
  parameter int TIME_BITS      = atsc_pkg::TIME_BITS_DEF,
  parameter int TIME_FRAC_BITS = atsc_pkg::TIME_FRAC_BITS_DEF,
  parameter int SPEED_BITS     = atsc_pkg::SPEED_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [atsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SPEED_BITS-1:0]          in_max_speed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [TIME_BITS-1:0]           out_step_size,
  output logic [TIME_BITS-1:0]           out_sim_time_now,
  output logic [atsc_pkg::COUNT_W-1:0]   out_step_index,
  output logic                           out_write_output,
  output logic                           out_finished,
  output logic                           out_step_too_small
);
  import atsc_pkg::*;

  localparam int SHIFT  = TIME_FRAC_BITS + SPEED_BITS - 48;
  localparam int NUM_SH = (SHIFT > 0) ? SHIFT : 0;
  localparam int DEN_SH = (SHIFT < 0) ? -SHIFT : 0;
  localparam int SPD_W  = (SPEED_BITS < 32) ? SPEED_BITS : 32;
  localparam int NUMF_W = COURANT_W + NUM_SH;
  localparam int NUM_W  = (NUMF_W < 64) ? NUMF_W : 64;
  localparam int DEN_W  = SPD_W + DEN_SH;
  localparam int QW     = (NUM_W > TIME_BITS) ? NUM_W : TIME_BITS;
  localparam int PROD_W = TIME_BITS + GROW_W;
  localparam int MCNT_W = $clog2(GROW_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MIN_GROW,
    S_MIN_MAX,
    S_MIN_INIT,
    S_ADVANCE,
    S_REPORT
  } state_t;

  // Configuration registers.
  logic [TIME_BITS-1:0] init_step_r;
  logic [TIME_BITS-1:0] max_dt_r;
  logic [TIME_BITS-1:0] min_dt_r;
  logic [GROW_W-1:0]    growth_r;
  logic [COURANT_W-1:0] courant_r;
  logic [MODE_W-1:0]    mode_r;
  logic [TIME_BITS-1:0] interval_r;
  logic [TIME_BITS-1:0] finish_r;

  // Controller state and working registers.
  state_t               state_r;
  logic [TIME_BITS-1:0] last_step_r;
  logic [TIME_BITS-1:0] sim_time_r;
  logic [TIME_BITS-1:0] mark_r;
  logic [COUNT_W-1:0]   step_cnt_r;
  logic                 first_r;
  logic                 spd_zero_r;
  logic [TIME_BITS-1:0] step_r;
  logic [TIME_BITS-1:0] mul_x_r;
  logic [GROW_W-1:0]    mul_g_r;
  logic [PROD_W-1:0]    mul_p_r;
  logic [MCNT_W-1:0]    mul_cnt_r;

  // Result registers.
  logic                 out_valid_r;
  logic [TIME_BITS-1:0] out_step_size_r;
  logic [TIME_BITS-1:0] out_sim_time_r;
  logic [COUNT_W-1:0]   out_step_index_r;
  logic                 out_write_r;
  logic                 out_finished_r;
  logic                 out_small_r;

  logic                 accept;
  logic                 first;
  logic [SPD_W-1:0]     speed;
  logic [NUMF_W-1:0]    num_full;
  logic [NUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [NUM_W-1:0]     div_quo;
  logic [TIME_BITS-1:0] time_max;
  logic [TIME_BITS-1:0] cour_sat;
  logic [TIME_BITS-1:0] cour;
  logic [TIME_BITS+3:0] grow_full;
  logic [TIME_BITS-1:0] grow_val;
  logic [TIME_BITS:0]   mul_sum;
  logic [TIME_BITS:0]   mark0_sum;
  logic [TIME_BITS:0]   adv_sum;
  logic [TIME_BITS:0]   mark_inc_sum;
  logic [TIME_BITS-1:0] mark0;
  logic [TIME_BITS-1:0] adv;
  logic [TIME_BITS-1:0] mark_inc;
  logic                 wr;
  logic                 out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_step_r <= '0;
      max_dt_r    <= TIME_BITS'(MAX_DT_RESET);
      min_dt_r    <= '0;
      growth_r    <= GROW_RESET;
      courant_r   <= '0;
      mode_r      <= MODE_TIME;
      interval_r  <= '0;
      finish_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INITIAL_STEP:    init_step_r <= TIME_BITS'(cfg_data);
        REG_MAX_DT:          max_dt_r    <= TIME_BITS'(cfg_data);
        REG_MIN_DT:          min_dt_r    <= TIME_BITS'(cfg_data);
        REG_GROWTH_RATE:     growth_r    <= cfg_data[GROW_W-1:0];
        REG_COURANT_LENGTH:  courant_r   <= cfg_data[COURANT_W-1:0];
        REG_OUTPUT_MODE:     mode_r      <= cfg_data[MODE_W-1:0];
        REG_OUTPUT_INTERVAL: interval_r  <= TIME_BITS'(cfg_data);
        REG_FINISH_TIME:     finish_r    <= TIME_BITS'(cfg_data);
        default:             init_step_r <= init_step_r;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign first    = (step_cnt_r == '0);
  assign speed    = SPD_W'(in_max_speed);
  assign time_max = '1;

  assign num_full = NUMF_W'(courant_r) << NUM_SH;
  assign div_num  = NUM_W'(num_full);
  assign div_den  = DEN_W'(speed) << DEN_SH;

  atsc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cour_sat = (QW'(div_quo) > QW'(time_max)) ? time_max : TIME_BITS'(div_quo);
  assign cour     = spd_zero_r ? init_step_r : cour_sat;

  assign mul_sum   = {1'b0, mul_p_r[PROD_W-1:GROW_W]} + (mul_g_r[0] ? {1'b0, mul_x_r} : '0);
  assign grow_full = mul_p_r[PROD_W-1:GROW_FRAC];
  assign grow_val  = (|grow_full[TIME_BITS+3:TIME_BITS]) ? time_max
                                                         : grow_full[TIME_BITS-1:0];

  assign mark0_sum    = {1'b0, sim_time_r} + {1'b0, interval_r};
  assign adv_sum      = {1'b0, sim_time_r} + {1'b0, step_r};
  assign mark_inc_sum = {1'b0, mark_r} + {1'b0, interval_r};
  assign mark0    = mark0_sum[TIME_BITS] ? time_max : mark0_sum[TIME_BITS-1:0];
  assign adv      = adv_sum[TIME_BITS] ? time_max : adv_sum[TIME_BITS-1:0];
  assign mark_inc = mark_inc_sum[TIME_BITS] ? time_max : mark_inc_sum[TIME_BITS-1:0];

  always_comb begin
    if (mode_r == MODE_TIME) begin
      wr = (sim_time_r >= mark_r);
    end else if (mode_r == MODE_STEP) begin
      wr = (TIME_BITS'(step_cnt_r) >= mark_r);
    end else begin
      wr = 1'b0;
    end
  end

  assign out_load = (state_r == S_REPORT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_step_r <= '0;
      sim_time_r  <= '0;
      mark_r      <= '0;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            first_r    <= first;
            spd_zero_r <= (speed == '0);
            mul_x_r    <= first ? init_step_r : last_step_r;
            mul_g_r    <= growth_r;
            mul_p_r    <= '0;
            mul_cnt_r  <= MCNT_W'(GROW_W);
            if (first) begin
              mark_r <= (mode_r == MODE_TIME) ? mark0 : '0;
            end
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (mul_cnt_r != '0) begin
            mul_p_r   <= {mul_sum, mul_p_r[GROW_W-1:1]};
            mul_g_r   <= mul_g_r >> 1;
            mul_cnt_r <= mul_cnt_r - 1'b1;
          end
          if (div_done) begin
            state_r <= S_MIN_GROW;
          end
        end
        S_MIN_GROW: begin
          step_r  <= (cour < grow_val) ? cour : grow_val;
          state_r <= S_MIN_MAX;
        end
        S_MIN_MAX: begin
          if (max_dt_r < step_r) begin
            step_r <= max_dt_r;
          end
          state_r <= S_MIN_INIT;
        end
        S_MIN_INIT: begin
          if (first_r && (init_step_r < step_r)) begin
            step_r <= init_step_r;
          end
          state_r <= S_ADVANCE;
        end
        S_ADVANCE: begin
          sim_time_r  <= adv;
          last_step_r <= step_r;
          state_r     <= S_REPORT;
        end
        S_REPORT: begin
          if (out_load) begin
            out_valid_r      <= 1'b1;
            out_step_size_r  <= step_r;
            out_sim_time_r   <= sim_time_r;
            out_step_index_r <= step_cnt_r;
            out_write_r      <= wr;
            out_finished_r   <= (sim_time_r > finish_r);
            out_small_r      <= (step_r < min_dt_r);
            if (wr) begin
              mark_r <= mark_inc;
            end
            if (step_cnt_r != '1) begin
              step_cnt_r <= step_cnt_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_size      = out_step_size_r;
  assign out_sim_time_now   = out_sim_time_r;
  assign out_step_index     = out_step_index_r;
  assign out_write_output   = out_write_r;
  assign out_finished       = out_finished_r;
  assign out_step_too_small = out_small_r;

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIV)) else $error("transaction did not start the divider");
  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_step_size_r <= max_dt_r)) else $error("step exceeds max_dt");
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (step_cnt_r != '0)) else $error("step count wrapped to zero");

endmodule
